### src/radix85_95_word_encoder_top_defines.svh
// Assertion macros for the radix 85/95 word encoder.
// Taken in by the top level; expects clk_i and rst_ni in scope.
`ifndef RADIX85_95_WORD_ENCODER_TOP_DEFINES_SVH
`define RADIX85_95_WORD_ENCODER_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
`define R85E_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define R85E_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define R85E_ASSERT(label, prop, msg)
`define R85E_ASSERT_RST(label, prop, msg)
`endif
`endif

### src/r85e_pkg.sv
// Types and constants shared by the radix 85/95 word encoder.
// No dependencies.
package r85e_pkg;

  localparam int unsigned DigitsPerWord = 5;
  localparam int unsigned FracBits      = 65;

  localparam logic [6:0] CharBase  = 7'h20;
  localparam logic [6:0] CharNul   = 7'h00;
  localparam logic [6:0] CharMax   = 7'h7e;
  localparam logic [6:0] RadixLow  = 7'd85;
  localparam logic [6:0] RadixHigh = 7'd95;

  // config register index, taken from paddr[2]
  localparam logic RegRadixMode = 1'b0;

  // word * Recip / 2^65 = word / radix^5, rounded up, exact enough for 5 digits
  localparam logic [66:0] FracOne = 67'd1 << FracBits;
  localparam logic [66:0] LowPow5 =
    67'(RadixLow) * 67'(RadixLow) * 67'(RadixLow) * 67'(RadixLow) * 67'(RadixLow);
  localparam logic [66:0] HighPow5 =
    67'(RadixHigh) * 67'(RadixHigh) * 67'(RadixHigh) * 67'(RadixHigh) * 67'(RadixHigh);
  localparam logic [32:0] RecipLow  = 33'((FracOne + LowPow5 - 67'd1) / LowPow5);
  localparam logic [32:0] RecipHigh = 33'((FracOne + HighPow5 - 67'd1) / HighPow5);

  typedef struct packed {
    logic [31:0] word_value;
    logic        final_word;
  } r85e_in_t;

  typedef struct packed {
    logic [6:0] out_char;
    logic       last_of_run;
  } r85e_out_t;

  typedef struct packed {
    logic [FracBits-1:0] frac;
    logic                zero;
    logic                final_word;
    logic                radix_sel;
  } r85e_cmd_t;

  typedef struct packed {
    logic cmd_pop;
    logic emit;
  } r85e_bk_ctl_t;

  typedef enum logic [1:0] {
    BkIdle,
    BkZero,
    BkDigit,
    BkTerm
  } r85e_bk_state_e;

endpackage

### src/r85e_fifo.sv
// Small register queue with push/full and pop/empty sides.
// Generic over entry type; no package dependency.
module r85e_fifo #(
  parameter int unsigned DEPTH = 2,
  parameter type T = logic
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  T     data_i,
  output logic full_o,
  input  logic pop_i,
  output T     data_o,
  output logic empty_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  T               mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CntW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    case ({do_push, do_pop})
      2'b10:   count_d = count_q + CntW'(1);
      2'b01:   count_d = count_q - CntW'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

### src/r85e_front.sv
// Front end: classifies an incoming word and scales it to a base-r^5 fraction.
// Depends on r85e_pkg.
module r85e_front import r85e_pkg::*; (
  input  logic      push_i,
  input  r85e_in_t  in_i,
  input  logic      radix_mode_i,
  input  logic      cmd_full_i,
  output logic      cmd_push_o,
  output r85e_cmd_t cmd_o
);

  logic [32:0]         recip;
  logic [FracBits-1:0] scaled;

  assign recip  = radix_mode_i ? RecipHigh : RecipLow;
  assign scaled = FracBits'(in_i.word_value) * FracBits'(recip);

  assign cmd_push_o       = push_i && !cmd_full_i;
  assign cmd_o.frac       = scaled;
  assign cmd_o.zero       = (in_i.word_value == 32'd0);
  assign cmd_o.final_word = in_i.final_word;
  assign cmd_o.radix_sel  = radix_mode_i;

endmodule

### src/r85e_back.sv
// Back end: character sequencer, one character per cycle from a queued command
// while the result queue has room. Depends on r85e_pkg.
module r85e_back import r85e_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cmd_empty_i,
  input  r85e_cmd_t    cmd_i,
  input  logic         out_full_i,
  output r85e_bk_ctl_t ctl_o,
  output r85e_out_t    out_o
);

  r85e_bk_state_e      state_q, state_d;
  logic [FracBits-1:0] frac_q, frac_d;
  logic [2:0]          cnt_q, cnt_d;
  logic                final_q, final_d;
  logic                radix_q, radix_d;
  logic [FracBits+6:0] prod;
  logic [6:0]          digit;
  logic                load;

  // shift the next digit out of the fraction
  assign prod  = radix_q ? ((FracBits+7)'(frac_q) * (FracBits+7)'(RadixHigh))
                         : ((FracBits+7)'(frac_q) * (FracBits+7)'(RadixLow));
  assign digit = prod[FracBits+6:FracBits];

  always_comb begin
    state_d           = state_q;
    frac_d            = frac_q;
    cnt_d             = cnt_q;
    final_d           = final_q;
    radix_d           = radix_q;
    load              = 1'b0;
    ctl_o.emit        = 1'b0;
    ctl_o.cmd_pop     = 1'b0;
    out_o.out_char    = CharNul;
    out_o.last_of_run = 1'b0;

    unique case (state_q)
      BkIdle: begin
        load = 1'b1;
      end
      BkZero: begin
        if (!out_full_i) begin
          ctl_o.emit        = 1'b1;
          out_o.last_of_run = !final_q;
          if (final_q) begin
            state_d = BkTerm;
          end else begin
            load = 1'b1;
          end
        end
      end
      BkDigit: begin
        if (!out_full_i) begin
          ctl_o.emit        = 1'b1;
          out_o.out_char    = CharBase + digit;
          frac_d            = prod[FracBits-1:0];
          cnt_d             = cnt_q + 3'd1;
          if (cnt_q == 3'(DigitsPerWord - 1)) begin
            out_o.last_of_run = !final_q;
            if (final_q) begin
              state_d = BkTerm;
            end else begin
              load = 1'b1;
            end
          end
        end
      end
      BkTerm: begin
        if (!out_full_i) begin
          ctl_o.emit        = 1'b1;
          out_o.last_of_run = 1'b1;
          load              = 1'b1;
        end
      end
      default: state_d = BkIdle;
    endcase

    // next command starts in the cycle the previous one finishes
    if (load) begin
      if (!cmd_empty_i) begin
        ctl_o.cmd_pop = 1'b1;
        frac_d        = cmd_i.frac;
        final_d       = cmd_i.final_word;
        radix_d       = cmd_i.radix_sel;
        cnt_d         = 3'd0;
        state_d       = cmd_i.zero ? BkZero : BkDigit;
      end else begin
        state_d = BkIdle;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BkIdle;
      cnt_q   <= 3'd0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    frac_q  <= frac_d;
    final_q <= final_d;
    radix_q <= radix_d;
  end

endmodule

### src/radix85_95_word_encoder_top.sv
// Radix 85/95 word encoder. Each accepted 32-bit word (first byte most
// significant) becomes five printable characters, space plus a base 85 or
// base 95 digit, most significant first; a zero word becomes a single NUL,
// and a word marked final is followed by a NUL terminator. The last
// character of each word carries last_of_run, or for a final word its
// terminator does. The back-end sequencer emits one character per cycle
// while the result queue has room. The front end scales the word with one
// 32x33 multiply in the accept cycle and queues it, so new words are taken
// while earlier ones are still being emitted.
// Depends on r85e_pkg, r85e_fifo, r85e_front, r85e_back and the defines header.
`include "radix85_95_word_encoder_top_defines.svh"

module radix85_95_word_encoder_top import r85e_pkg::*; #(
  parameter int unsigned CmdDepth = 2,
  parameter int unsigned OutDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  r85e_in_t    in_data_i,
  output logic        empty,
  input  logic        pop,
  output r85e_out_t   out_data_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic         radix_mode_q;
  logic         cfg_wr;
  logic         cmd_push;
  logic         cmd_empty;
  r85e_cmd_t    cmd_in;
  r85e_cmd_t    cmd_head;
  r85e_bk_ctl_t bk_ctl;
  r85e_out_t    bk_out;
  logic         out_full;
  logic         out_char_ok;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == RegRadixMode);
  assign prdata = (paddr[2] == RegRadixMode) ? {31'd0, radix_mode_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_mode_q <= 1'b0;
    end else if (cfg_wr) begin
      radix_mode_q <= pwdata[0];
    end
  end

  r85e_front u_front (
    .push_i       (push),
    .in_i         (in_data_i),
    .radix_mode_i (radix_mode_q),
    .cmd_full_i   (full),
    .cmd_push_o   (cmd_push),
    .cmd_o        (cmd_in)
  );

  r85e_fifo #(
    .DEPTH (CmdDepth),
    .T     (r85e_cmd_t)
  ) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .full_o  (full),
    .pop_i   (bk_ctl.cmd_pop),
    .data_o  (cmd_head),
    .empty_o (cmd_empty)
  );

  r85e_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_empty_i (cmd_empty),
    .cmd_i       (cmd_head),
    .out_full_i  (out_full),
    .ctl_o       (bk_ctl),
    .out_o       (bk_out)
  );

  r85e_fifo #(
    .DEPTH (OutDepth),
    .T     (r85e_out_t)
  ) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (bk_ctl.emit),
    .data_i  (bk_out),
    .full_o  (out_full),
    .pop_i   (pop),
    .data_o  (out_data_o),
    .empty_o (empty)
  );

  assign out_char_ok = (out_data_o.out_char == CharNul) ||
                       (out_data_o.out_char >= CharBase && out_data_o.out_char <= CharMax);

  `R85E_ASSERT(a_char_printable, !empty |-> out_char_ok, "result character out of range")
  `R85E_ASSERT(a_no_emit_when_full, !(bk_ctl.emit && out_full), "character emitted into full result queue")
  `R85E_ASSERT(a_pop_needs_cmd, !(bk_ctl.cmd_pop && cmd_empty), "command popped from empty queue")
  `R85E_ASSERT_RST(a_reset_empty, !rst_ni |-> (empty && !full), "queues not clear in reset")

endmodule

### bench/radix85_95_word_encoder_top_tb.sv
// Self-checking bench for the radix 85/95 word encoder: queue-style word input,
// per-character output checked against an in-bench encoder, APB mode register.
// Depends on r85e_pkg and radix85_95_word_encoder_top.
module radix85_95_word_encoder_top_tb;
  import r85e_pkg::*;

  localparam int ClkPeriod     = 4;
  localparam int ResetCycles   = 12;
  localparam int HoldCycles    = 300;
  localparam int DrainCycles   = 16;
  localparam int TimeoutCycles = 400000;

  localparam logic [2:0] AddrRadixMode = {RegRadixMode, 2'b00};
  localparam logic [2:0] AddrNoReg     = 3'd4;

  logic        clk_i;
  logic        rst_ni;
  logic        push;
  logic        full;
  r85e_in_t    in_data;
  logic        empty;
  logic        pop;
  r85e_out_t   out_data;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  logic        radix_mode;
  r85e_out_t   pending_chars[$];
  int unsigned words_sent;
  int unsigned chars_seen;
  int unsigned errors;
  bit          hold_req;
  bit          quiet;

  radix85_95_word_encoder_top uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_data_i  (in_data),
    .empty      (empty),
    .pop        (pop),
    .out_data_o (out_data),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  function automatic void encode_word(r85e_in_t item);
    logic [31:0]  rest;
    logic [6:0]   radix;
    logic [6:0]   digit [DigitsPerWord];
    r85e_out_t    beat;
    rest  = item.word_value;
    radix = radix_mode ? RadixHigh : RadixLow;
    if (rest == '0) begin
      beat.out_char    = CharNul;
      beat.last_of_run = !item.final_word;
      pending_chars.push_back(beat);
    end else begin
      for (int i = DigitsPerWord - 1; i >= 0; i--) begin
        digit[i] = CharBase + 7'(rest % radix);
        rest     = rest / radix;
      end
      for (int i = 0; i < DigitsPerWord; i++) begin
        beat.out_char    = digit[i];
        beat.last_of_run = !item.final_word && (i == DigitsPerWord - 1);
        pending_chars.push_back(beat);
      end
    end
    if (item.final_word) begin
      beat.out_char    = CharNul;
      beat.last_of_run = 1'b1;
      pending_chars.push_back(beat);
    end
  endfunction

  always @(posedge clk_i) begin
    r85e_out_t want;
    if (rst_ni && pop && !empty) begin
      chars_seen++;
      if (pending_chars.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat, expected none, actual char %h last %b",
                 $time, out_data.out_char, out_data.last_of_run);
      end else begin
        want = pending_chars.pop_front();
        if (out_data.out_char !== want.out_char) begin
          errors++;
          $display("%0t: out_char mismatch, expected %h, actual %h",
                   $time, want.out_char, out_data.out_char);
        end
        if (out_data.last_of_run !== want.last_of_run) begin
          errors++;
          $display("%0t: last_of_run mismatch, expected %b, actual %b",
                   $time, want.last_of_run, out_data.last_of_run);
        end
      end
    end
  end

  // receiver: random stall bursts, one long hold on request, none when quiet
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        pop <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        hold_req = 1'b0;
      end else if (quiet) begin
        pop <= 1'b1;
      end else if ($urandom_range(0, 3) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(0, 9)) @(negedge clk_i);
      end else begin
        pop <= 1'b1;
        repeat ($urandom_range(0, 15)) @(negedge clk_i);
      end
    end
  end

  task automatic send_word(input r85e_in_t item);
    @(negedge clk_i);
    push    <= 1'b1;
    in_data <= item;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    encode_word(item);
    words_sent++;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      @(negedge clk_i);
      push <= 1'b0;
      repeat ($urandom_range(0, 9)) @(negedge clk_i);
    end
  endtask

  task automatic settle();
    @(negedge clk_i);
    push <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (addr == AddrRadixMode) radix_mode = value[0];
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_mode_reg();
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= AddrRadixMode;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata !== {31'b0, radix_mode}) begin
      errors++;
      $display("%0t: radix_mode readback mismatch, expected %h, actual %h",
               $time, {31'b0, radix_mode}, prdata);
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic r85e_in_t corner_item(int k);
    r85e_in_t item;
    item.final_word = 1'b0;
    case (k)
      0:       item.word_value = 32'h0000_0000;
      1:       begin item.word_value = 32'h0000_0000; item.final_word = 1'b1; end
      2:       item.word_value = 32'h0000_0001;
      3:       item.word_value = 32'hFFFF_FFFF;
      4:       begin item.word_value = 32'hFFFF_FFFF; item.final_word = 1'b1; end
      5:       item.word_value = 32'h8000_0000;
      6:       item.word_value = 32'h0000_0055;
      7:       item.word_value = 32'h0000_005F;
      8:       begin item.word_value = 32'h7FFF_FFFF; item.final_word = 1'b1; end
      9:       item.word_value = 32'h0102_0304;
      10:      item.word_value = 32'hAAAA_AAAA;
      default: begin item.word_value = 32'h5555_5555; item.final_word = 1'b1; end
    endcase
    return item;
  endfunction

  function automatic r85e_in_t random_item();
    r85e_in_t item;
    case ($urandom_range(0, 7))
      0:       item.word_value = 32'h0;
      1:       item.word_value = $urandom_range(0, 200);
      2:       item.word_value = 32'hFFFF_FFFF - $urandom_range(0, 200);
      default: item.word_value = $urandom;
    endcase
    item.final_word = ($urandom_range(0, 3) == 0);
    return item;
  endfunction

  task automatic send_corners();
    for (int k = 0; k < 12; k++) send_word(corner_item(k));
    settle();
  endtask

  // reset value selects base 85
  task automatic test_base85_corners();
    check_mode_reg();
    send_corners();
  endtask

  // only bit 0 is kept; a write to an unmapped index changes nothing
  task automatic test_mode_register();
    write_reg(AddrRadixMode, 32'hFFFF_FFFF);
    check_mode_reg();
    write_reg(AddrNoReg, 32'h0000_0000);
    check_mode_reg();
    write_reg(AddrRadixMode, 32'hFFFF_FFFE);
    check_mode_reg();
    write_reg(AddrRadixMode, 32'h0000_0001);
    check_mode_reg();
  endtask

  task automatic test_base95_corners();
    send_corners();
  endtask

  task automatic test_random_mix();
    for (int phase = 0; phase < 4; phase++) begin
      write_reg(AddrRadixMode, {31'($urandom_range(0, 32'h7FFF_FFFF)), phase[0]});
      check_mode_reg();
      repeat (70) send_word(random_item());
      settle();
    end
  endtask

  task automatic test_full_stall();
    hold_req = 1'b1;
    repeat (20) send_word(random_item());
    settle();
  endtask

  task automatic test_steady_stream();
    quiet = 1'b1;
    write_reg(AddrRadixMode, 32'h0000_0000);
    repeat (10) send_word(random_item());
    settle();
    write_reg(AddrRadixMode, 32'h0000_0001);
    repeat (10) send_word(random_item());
    settle();
  endtask

  initial begin
    clk_i      = 1'b0;
    rst_ni     = 1'b1;
    push       = 1'b0;
    in_data    = '0;
    pop        = 1'b0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    radix_mode = 1'b0;
    words_sent = 0;
    chars_seen = 0;
    errors     = 0;
    hold_req   = 1'b0;
    quiet      = 1'b0;
    #1 rst_ni = 1'b0;
    repeat (ResetCycles) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_base85_corners();
    test_mode_register();
    test_base95_corners();
    test_random_mix();
    test_full_stall();
    test_steady_stream();

    $display("Covered %0d words and %0d characters in base 85 and base 95,", words_sent,
             chars_seen);
    $display("with zero and final words, register writes and a long output hold.");
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #(TimeoutCycles * ClkPeriod);
    $display("timeout with %0d characters outstanding", pending_chars.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

### radix85_95_word_encoder_top.f
+incdir+src
src/r85e_pkg.sv
src/r85e_fifo.sv
src/r85e_front.sv
src/r85e_back.sv
src/radix85_95_word_encoder_top.sv
bench/radix85_95_word_encoder_top_tb.sv
